[rtl/core/ffra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared widths, status codes and sequencer states of the region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    // Field widths of a request and response word
    localparam int START_W = 13;
    localparam int END_W   = 14;
    localparam int SIZE_W  = 14;
    localparam int SUM_W   = 15;  // last end plus size, room for the carry

    // Pool size in units
    localparam int POOL_UNITS = 8192;
    localparam logic [SUM_W-1:0] POOL_LIMIT = SUM_W'(POOL_UNITS);

    // Request operation codes
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_UP,
        S_INS,
        S_DOWN,
        S_DONE
    } t_state;

endpackage

[rtl/core/ffra_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_req_if
// Request channel: operation, allocate size and start of region to free.
// ----------------------------------------------------------------------------
interface ffra_req_if
    import ffra_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               func;
    logic [SIZE_W-1:0]  alloc_size;
    logic [START_W-1:0] free_start;

    modport source (output valid, func, alloc_size, free_start, input ready);
    modport sink   (input valid, func, alloc_size, free_start, output ready);
endinterface

[rtl/core/ffra_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_rsp_if
// Response channel: status and bounds of the region allocated or freed.
// ----------------------------------------------------------------------------
interface ffra_rsp_if
    import ffra_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [START_W-1:0] region_start;
    logic [END_W-1:0]   region_end;

    modport source (output valid, status, region_start, region_end, input ready);
    modport sink   (input valid, status, region_start, region_end, output ready);
endinterface

[rtl/core/first_fit_region_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over a sorted table of half-open regions in a pool.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake      Word
//  i_req    in   valid/ready    func, alloc_size, free_start
//  o_rsp    out  valid/ready    status, region_start, region_end
//
//  A request walks n table entries (one per cycle, bounded by the read port
//  of the table RAM), then moves m entries to open or close a slot (one per
//  cycle), plus placement check and insert for an allocate, and the
//  hand-off for both. n + m never exceeds the entry count; a full table or
//  a zero size goes straight to the hand-off.
//  Synchronous active-low reset empties the table; no clearing pass.
//  A finished word waits in the output register; the next request is taken
//  meanwhile, and only its hand-off stalls until o_rsp is free.
// ----------------------------------------------------------------------------
module first_fit_region_allocator
    import ffra_pkg::*;
#(
    parameter int MAX_REGIONS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffra_req_if.sink    i_req,
    ffra_rsp_if.source  o_rsp
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int DW = START_W + END_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

    // Sequencer and request registers
    t_state              r_state, n_state;
    logic                r_func;
    logic [SIZE_W-1:0]   r_size;
    logic [START_W-1:0]  r_fstart;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_pos, n_pos;
    logic [END_W-1:0]    r_last_end, n_last_end;
    t_status             r_res_status, n_res_status;
    logic [START_W-1:0]  r_res_start, n_res_start;
    logic [END_W-1:0]    r_res_end, n_res_end;

    // Output register
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status;
    logic [START_W-1:0]  r_out_start;
    logic [END_W-1:0]    r_out_end;

    // Table RAM ports
    logic                w_we;
    logic [IW-1:0]       w_waddr, w_raddr;
    logic [DW-1:0]       w_wdata, w_q;
    logic [START_W-1:0]  w_q_start;
    logic [END_W-1:0]    w_q_end;

    // Shared compare unit and index arithmetic
    logic                w_in_acc;
    logic                w_out_free;
    logic [SUM_W-1:0]    w_sum;
    logic                w_fit;
    logic                w_hit;
    logic [CW-1:0]       w_k_inc, w_k_dec;
    logic                w_last;

    ffra_ram #(
        .DEPTH (MAX_REGIONS),
        .AW    (IW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_q_start = w_q[START_W-1:0];
    assign w_q_end   = w_q[DW-1:START_W];

    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // End of the candidate region; fits a gap or the pool if not past its bound
    assign w_sum   = SUM_W'(r_last_end) + SUM_W'(r_size);
    assign w_fit   = (w_sum <= POOL_LIMIT);
    assign w_hit   = (r_func == FN_ALLOC) ? (SUM_W'(w_q_start) >= w_sum)
                                          : (w_q_start == r_fstart);
    assign w_k_inc = r_k + CW'(1);
    assign w_k_dec = r_k - CW'(1);
    assign w_last  = (w_k_inc == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_req.func == FN_ALLOC) begin
                        if (r_count == MAX_CNT || i_req.alloc_size == '0) begin
                            n_state = S_DONE;
                        end else if (r_count == '0) begin
                            n_state = S_PLACE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_func == FN_ALLOC) begin
                    if (w_hit || w_last) begin
                        n_state = S_PLACE;
                    end
                end else if (w_last) begin
                    n_state = S_DONE;
                end else if (w_hit) begin
                    n_state = S_DOWN;
                end
            end
            S_PLACE: begin
                if (!w_fit || r_pos == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (r_k == r_pos) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_state = S_DONE;
            end
            S_DOWN: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Address of the last valid entry
    function automatic logic [IW-1:0] w_dec_count();
        logic [CW-1:0] v;
        v = r_count - CW'(1);
        return v[IW-1:0];
    endfunction

    // Datapath control, table port control and results
    always_comb begin
        n_count      = r_count;
        n_k          = r_k;
        n_pos        = r_pos;
        n_last_end   = r_last_end;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_end    = r_res_end;
        w_we         = 1'b0;
        w_waddr      = r_pos[IW-1:0];
        w_wdata      = {w_sum[END_W-1:0], r_last_end[START_W-1:0]};
        w_raddr      = w_k_inc[IW-1:0];
        case (r_state)
            S_IDLE: begin
                w_raddr = '0;
                if (w_in_acc) begin
                    n_k          = '0;
                    n_pos        = '0;
                    n_last_end   = '0;
                    n_res_start  = '0;
                    n_res_end    = '0;
                    n_res_status = ST_NOTFOUND;
                    if (i_req.func == FN_ALLOC) begin
                        n_res_status = (r_count == MAX_CNT) ? ST_FULL : ST_NOSPACE;
                    end
                end
            end
            S_SCAN: begin
                // next entry is read ahead every cycle
                n_k = w_k_inc;
                if (r_func == FN_ALLOC) begin
                    if (w_hit) begin
                        n_pos = r_k;
                    end else begin
                        n_last_end = w_q_end;
                        if (w_last) begin
                            n_pos = r_count;
                        end
                    end
                end else if (w_hit) begin
                    n_pos        = r_k;
                    n_res_status = ST_OK;
                    n_res_start  = w_q_start;
                    n_res_end    = w_q_end;
                    if (w_last) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_PLACE: begin
                w_raddr = w_dec_count();
                if (!w_fit) begin
                    n_res_status = ST_NOSPACE;
                end else if (r_pos == r_count) begin
                    w_we         = 1'b1;
                    n_count      = r_count + CW'(1);
                    n_res_status = ST_OK;
                    n_res_start  = r_last_end[START_W-1:0];
                    n_res_end    = w_sum[END_W-1:0];
                end else begin
                    n_k = r_count - CW'(1);
                end
            end
            S_UP: begin
                // move entry k up by one, reading the one below it
                w_we    = 1'b1;
                w_waddr = w_k_inc[IW-1:0];
                w_wdata = w_q;
                w_raddr = w_k_dec[IW-1:0];
                if (r_k != r_pos) begin
                    n_k = w_k_dec;
                end
            end
            S_INS: begin
                w_we         = 1'b1;
                n_count      = r_count + CW'(1);
                n_res_status = ST_OK;
                n_res_start  = r_last_end[START_W-1:0];
                n_res_end    = w_sum[END_W-1:0];
            end
            S_DOWN: begin
                // move entry k down by one, reading the one above it
                w_we    = 1'b1;
                w_waddr = w_k_dec[IW-1:0];
                w_wdata = w_q;
                if (w_last) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_k = w_k_inc;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register load and release
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_DONE && w_out_free) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func   <= i_req.func;
            r_size   <= i_req.alloc_size;
            r_fstart <= i_req.free_start;
        end
        r_k          <= n_k;
        r_pos        <= n_pos;
        r_last_end   <= n_last_end;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_end    <= n_res_end;
        if (r_state == S_DONE && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_start  <= r_res_start;
            r_out_end    <= r_res_end;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.region_start = r_out_start;
    assign o_rsp.region_end   = r_out_end;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("region count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)
                  || r_count + CW'(1) == $past(r_count)))
        else $error("region count moved by more than one");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_req.func == FN_ALLOC && r_count == MAX_CNT)
        |=> (r_state == S_DONE && r_res_status == ST_FULL))
        else $error("allocate on full table not rejected");

    a_ok_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OK) |-> (r_out_end > END_W'(r_out_start)))
        else $error("ok word with empty region");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state != S_IDLE && r_state != S_DONE))
        else $error("table written outside a request");

endmodule

[rtl/core/ffra_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ram
// Region table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 27
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/ffra_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches both channels of the region allocator, predicts each response word
// from its own copy of the region table and compares it field by field.
// ----------------------------------------------------------------------------
module ffra_checker
    import ffra_pkg::*;
#(
    parameter int MAX_REGIONS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ffra_req_if  req,
    ffra_rsp_if  rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] rstart;
        logic [END_W-1:0]   rend;
    } t_region_rsp;

    // Shadow region table, sorted by start; entries at or above the count are never read
    logic [START_W-1:0] tab_start [MAX_REGIONS];
    logic [END_W-1:0]   tab_end   [MAX_REGIONS];
    int                 tab_count;

    // Predicted response words, oldest first
    t_region_rsp        region_rsp_q [$];
    t_region_rsp        predicted;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        tab_count    = 0;
    end

    // First-fit placement; updates the shadow table on success
    function automatic t_region_rsp first_fit_place(logic [SIZE_W-1:0] size);
        t_region_rsp w;
        int          last_end;
        int          pos;
        int          k;
        bit          found;
        w.status = ST_NOSPACE;
        w.rstart = '0;
        w.rend   = '0;
        last_end = 0;
        pos      = tab_count;
        found    = 1'b0;
        // Full table wins over every other outcome
        if (tab_count >= MAX_REGIONS) begin
            w.status = ST_FULL;
            return w;
        end
        if (size == '0)
            return w;
        for (k = 0; k < tab_count; k++) begin
            if (!found) begin
                if (int'(tab_start[k]) - last_end >= int'(size)) begin
                    pos   = k;
                    found = 1'b1;
                end else begin
                    last_end = int'(tab_end[k]);
                end
            end
        end
        if (last_end + int'(size) > POOL_UNITS)
            return w;
        // Open a slot at pos
        for (k = tab_count; k > pos; k--) begin
            tab_start[k] = tab_start[k-1];
            tab_end[k]   = tab_end[k-1];
        end
        tab_start[pos] = START_W'(last_end);
        tab_end[pos]   = END_W'(last_end + int'(size));
        tab_count++;
        w.status = ST_OK;
        w.rstart = START_W'(last_end);
        w.rend   = END_W'(last_end + int'(size));
        return w;
    endfunction

    // Removal by start; table unchanged when the start is unknown
    function automatic t_region_rsp region_release(logic [START_W-1:0] st);
        t_region_rsp w;
        int          k;
        int          hit;
        w.status = ST_NOTFOUND;
        w.rstart = '0;
        w.rend   = '0;
        hit      = -1;
        for (k = 0; k < tab_count; k++) begin
            if (hit < 0 && tab_start[k] == st)
                hit = k;
        end
        if (hit < 0)
            return w;
        w.status = ST_OK;
        w.rstart = tab_start[hit];
        w.rend   = tab_end[hit];
        // Close the slot
        for (k = hit; k + 1 < tab_count; k++) begin
            tab_start[k] = tab_start[k+1];
            tab_end[k]   = tab_end[k+1];
        end
        tab_count--;
        return w;
    endfunction

    task automatic report_field(string name, int exp_val, logic [END_W-1:0] act_val);
        o_fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val,
                 act_val);
    endtask

    // Response checked before the request of the same edge: it always belongs
    // to an earlier word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tab_count = 0;
            region_rsp_q.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (region_rsp_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected response, expected none, got %0d/%0d/%0d",
                             $time, rsp.status, rsp.region_start, rsp.region_end);
                end else begin
                    predicted = region_rsp_q.pop_front();
                    if (rsp.status !== predicted.status)
                        report_field("status", int'(predicted.status), END_W'(rsp.status));
                    if (rsp.region_start !== predicted.rstart)
                        report_field("region_start", int'(predicted.rstart),
                                     END_W'(rsp.region_start));
                    if (rsp.region_end !== predicted.rend)
                        report_field("region_end", int'(predicted.rend), rsp.region_end);
                end
            end
            if (req.valid && req.ready) begin
                if (req.func == FN_ALLOC)
                    region_rsp_q.push_back(first_fit_place(req.alloc_size));
                else
                    region_rsp_q.push_back(region_release(req.free_start));
            end
        end
        o_pending = region_rsp_q.size();
    end

endmodule

[tb/tb_first_fit_region_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator
// Drives directed corner words, a table fill to the brim and a long random
// mix of allocate and free words, with random stalls on both channels; the
// checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_first_fit_region_allocator;
    import ffra_pkg::*;

    localparam int MAX_REGIONS     = 64;
    localparam int N_RANDOM        = 600;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 2 * MAX_REGIONS + 8;
    localparam int RSP_HOLD_CYCLES = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int   fail_count;
    int   pending;

    bit   req_idle_en  = 1'b1;
    bit   rsp_idle_en  = 1'b1;
    bit   hold_trigger = 1'b0;

    int unsigned cycle_cnt = 0;

    // Starts of live regions as seen on the response channel; steers frees
    logic [START_W-1:0] live_starts [$];
    logic               issued_func_q [$];
    logic               rsp_func;

    ffra_req_if req_ch ();
    ffra_rsp_if rsp_ch ();

    first_fit_region_allocator #(
        .MAX_REGIONS (MAX_REGIONS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ffra_checker #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** first_fit_region_allocator: FAILED **");
            $finish;
        end
    end

    // Track allocated starts for the stimulus
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready && issued_func_q.size() > 0) begin
                rsp_func = issued_func_q.pop_front();
                if (rsp_func == FN_ALLOC && rsp_ch.status == ST_OK)
                    live_starts.push_back(rsp_ch.region_start);
            end
            if (req_ch.valid && req_ch.ready)
                issued_func_q.push_back(req_ch.func);
        end
    end

    // Response side: random stalls, plus one long hold-off on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_trigger) begin
                hold_trigger = 1'b0;
                rsp_ch.ready = 1'b0;
                repeat (RSP_HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (rsp_idle_en && $urandom_range(0, 99) < 26) begin
                rsp_ch.ready = 1'b0;
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Offer one word; returns at the falling edge after it is taken
    task automatic send_req(logic f, logic [SIZE_W-1:0] sz, logic [START_W-1:0] st);
        if (req_idle_en && $urandom_range(0, 99) < 26) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.func       = f;
        req_ch.alloc_size = sz;
        req_ch.free_start = st;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic alloc_req(logic [SIZE_W-1:0] sz);
        send_req(FN_ALLOC, sz, START_W'($urandom_range(0, POOL_UNITS - 1)));
    endtask

    task automatic free_req(logic [START_W-1:0] st);
        send_req(FN_FREE, SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)), st);
    endtask

    // Sender pause until every predicted word has come back
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly small sizes; a few large, zero and beyond the pool
    function automatic logic [SIZE_W-1:0] pick_size(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r == 0)
            return '0;
        if (r < 3)
            return SIZE_W'($urandom_range(POOL_UNITS + 1, (1 << SIZE_W) - 1));
        if (r < 6)
            return SIZE_W'($urandom_range(2048, POOL_UNITS));
        if (filling || r < 70)
            return SIZE_W'($urandom_range(1, 63));
        return SIZE_W'($urandom_range(64, 1024));
    endfunction

    initial begin
        int                 n;
        int                 roll;
        int                 idx;
        int                 alloc_pct;
        logic [START_W-1:0] st;

        req_ch.valid      = 1'b0;
        req_ch.func       = FN_ALLOC;
        req_ch.alloc_size = '0;
        req_ch.free_start = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: zero size, oversize, unknown start, exact fits, gap reuse
        alloc_req(SIZE_W'(0));
        free_req(START_W'(0));
        alloc_req(SIZE_W'((1 << SIZE_W) - 1));
        alloc_req(SIZE_W'(POOL_UNITS + 1));
        alloc_req(SIZE_W'(POOL_UNITS));
        alloc_req(SIZE_W'(1));
        free_req(START_W'(POOL_UNITS - 1));
        free_req(START_W'(0));
        alloc_req(SIZE_W'(100));
        alloc_req(SIZE_W'(200));
        alloc_req(SIZE_W'(300));
        free_req(START_W'(100));
        alloc_req(SIZE_W'(250));       // too big for the hole, goes after the last
        alloc_req(SIZE_W'(200));       // fills the hole exactly
        alloc_req(SIZE_W'(7342));      // ends exactly at the pool end
        alloc_req(SIZE_W'(1));
        free_req(START_W'(0));
        alloc_req(SIZE_W'(50));
        free_req(START_W'(101));
        free_req(START_W'(0));
        free_req(START_W'(100));
        free_req(START_W'(300));
        free_req(START_W'(600));
        free_req(START_W'(850));
        wait_drained();
        live_starts.delete();

        // Fill the table, then hit the full case, also with a zero size
        for (n = 0; n < MAX_REGIONS; n++)
            alloc_req(SIZE_W'($urandom_range(1, 100)));
        alloc_req(SIZE_W'($urandom_range(1, 100)));
        alloc_req(SIZE_W'(0));
        wait_drained();
        for (n = 0; n < MAX_REGIONS / 2 && live_starts.size() > 0; n++) begin
            idx = $urandom_range(0, live_starts.size() - 1);
            free_req(live_starts[idx]);
            live_starts.delete(idx);
        end

        // Random: fill and drain blocks alternate so the table swings to both ends
        for (n = 0; n < N_RANDOM; n++) begin
            req_idle_en = !(n >= 300 && n < 400);
            rsp_idle_en = !(n >= 300 && n < 400);
            if (n == 150)
                hold_trigger = 1'b1;
            if (n == 450)
                wait_drained();
            alloc_pct = ((n / 100) % 2 == 0) ? 80 : 30;
            roll      = $urandom_range(0, 99);
            if (roll < alloc_pct) begin
                alloc_req(pick_size((n / 100) % 2 == 0));
            end else if (roll < 92) begin
                if (live_starts.size() > 0) begin
                    idx = $urandom_range(0, live_starts.size() - 1);
                    st  = live_starts[idx];
                    // now and then keep it listed, so a later free repeats it
                    if ($urandom_range(0, 9) != 0)
                        live_starts.delete(idx);
                    free_req(st);
                end else begin
                    alloc_req(pick_size(1'b1));
                end
            end else begin
                free_req(START_W'($urandom_range(0, POOL_UNITS - 1)));
            end
        end

        // Drain and let the block settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("** first_fit_region_allocator: PASSED **");
        end else begin
            $display("** first_fit_region_allocator: FAILED **");
        end
        $finish;
    end

endmodule
